FILE: hw/rtl/npt_pkg.sv
// Shared types and constants for the address pool translator.
// Holds operation and result codes plus the controller/datapath command and status structs.
`default_nettype none

package npt_pkg;

	localparam int unsigned POOL_BITS_DEF = 8;
	localparam int unsigned ADDR_W        = 32;

	typedef enum logic [1:0] {
		OP_OUTBOUND = 2'd0,
		OP_INBOUND  = 2'd1,
		OP_RELEASE  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RES_FAIL     = 2'd0,
		RES_PUBLIC   = 2'd1,
		RES_INBOUND  = 2'd2,
		RES_RELEASED = 2'd3
	} res_t;

	// Commands from controller to datapath, valid for one cycle each.
	typedef struct packed {
		logic clr;         // clear the pool entry at the counter, advance
		logic restart;     // zero the counter and the scan-hit flag
		logic scan_owner;  // read slot at counter, look for a matching owner
		logic scan_free;   // read slot at scan start plus counter, look for a free slot
		logic rd_in;       // read the slot named by the request's host bits
		logic wr_bind;     // bind the found slot to the request address
		logic wr_free;     // free the found slot
		logic result;      // load the output register
		res_t res;         // which result to load
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		op_t  op;
		logic cnt_last;
		logic scan_over;
		logic found;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/npt_dp.sv
// Datapath of the address pool translator: pool memory, scan counter, request and output registers.
// Depends on npt_pkg; driven by commands from npt_ctrl.
`default_nettype none

module npt_dp import npt_pkg::*; #(
	parameter int unsigned POOL_BITS = POOL_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [1:0]        operation,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic                   ok,
	output logic [ADDR_W-1:0]      translated
);

	localparam int unsigned POOL_SIZE = 1 << POOL_BITS;
	localparam int unsigned CNT_W     = POOL_BITS + 1;
	localparam int unsigned MEM_W     = ADDR_W + 1;
	localparam int unsigned HI_W      = ADDR_W - POOL_BITS;

	// busy bit on top, owner address below
	logic [MEM_W-1:0]     pool_mem_q [POOL_SIZE];
	logic [MEM_W-1:0]     mem_rd_s1;

	op_t                  op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    pool_base_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 found_q;
	logic [POOL_BITS-1:0] hit_idx_q;
	logic [POOL_BITS-1:0] scan_start_q;
	logic                 valid_s1;
	logic                 free_s1;
	logic [POOL_BITS-1:0] idx_s1;
	logic                 out_valid_q;
	logic                 ok_q;
	logic [ADDR_W-1:0]    translated_q;

	logic [POOL_BITS-1:0] cnt_idx;
	logic                 cnt_full;
	logic                 issue;
	logic                 rd_en;
	logic [POOL_BITS-1:0] rd_idx;
	logic                 wr_en;
	logic [POOL_BITS-1:0] wr_idx;
	logic [MEM_W-1:0]     wr_data;
	logic                 rd_busy;
	logic [ADDR_W-1:0]    rd_owner;
	logic                 hit;
	logic [HI_W-1:0]      prefix_hi;
	logic                 in_hit;
	logic                 res_ok;
	logic [ADDR_W-1:0]    res_val;

	assign cnt_idx  = cnt_q[POOL_BITS-1:0];
	assign cnt_full = (cnt_q == CNT_W'(POOL_SIZE));
	assign issue    = (cmd.scan_owner || cmd.scan_free) && !cnt_full && !found_q;
	assign rd_en    = issue || cmd.rd_in;

	always_comb begin
		if (cmd.scan_free) begin
			rd_idx = scan_start_q + cnt_idx;
		end else if (cmd.rd_in) begin
			rd_idx = addr_q[POOL_BITS-1:0];
		end else begin
			rd_idx = cnt_idx;
		end
	end

	assign wr_en   = cmd.clr || cmd.wr_bind || cmd.wr_free;
	assign wr_idx  = cmd.clr ? cnt_idx : hit_idx_q;
	assign wr_data = {cmd.wr_bind, addr_q};

	assign rd_busy   = mem_rd_s1[MEM_W-1];
	assign rd_owner  = mem_rd_s1[ADDR_W-1:0];
	assign hit       = valid_s1 && (free_s1 ? !rd_busy : (rd_busy && (rd_owner == addr_q)));
	assign prefix_hi = pool_base_q[ADDR_W-1:POOL_BITS];
	assign in_hit    = rd_busy && (addr_q[ADDR_W-1:POOL_BITS] == prefix_hi);

	always_comb begin
		case (cmd.res)
			RES_PUBLIC: begin
				res_ok  = 1'b1;
				res_val = {prefix_hi, hit_idx_q};
			end
			RES_INBOUND: begin
				res_ok  = in_hit;
				res_val = in_hit ? rd_owner : '0;
			end
			RES_RELEASED: begin
				res_ok  = 1'b1;
				res_val = '0;
			end
			default: begin
				res_ok  = 1'b0;
				res_val = '0;
			end
		endcase
	end

	// pool memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pool_mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= pool_mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			valid_s1     <= 1'b0;
			scan_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_base_q <= cfg_wdata;
			end
			if (take || cmd.restart) begin
				cnt_q    <= '0;
				found_q  <= 1'b0;
				valid_s1 <= 1'b0;
			end else begin
				if (cmd.clr || issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				valid_s1 <= issue;
			end
			if (cmd.wr_bind) begin
				scan_start_q <= hit_idx_q + 1'b1;
			end
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= op_t'(operation);
			addr_q <= address;
		end
		if (issue) begin
			idx_s1  <= rd_idx;
			free_s1 <= cmd.scan_free;
		end
		if (hit && !found_q) begin
			hit_idx_q <= idx_s1;
		end
		if (cmd.result) begin
			ok_q         <= res_ok;
			translated_q <= res_val;
		end
	end

	assign sts.op        = op_q;
	assign sts.cnt_last  = (cnt_q == CNT_W'(POOL_SIZE - 1));
	assign sts.scan_over = cnt_full && !valid_s1;
	assign sts.found     = found_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign translated = translated_q;

`ifndef SYNTH
	a_bind_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_bind |-> found_q)
		else $error("bind issued without a free slot found");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.wr_bind, cmd.wr_free}))
		else $error("more than one pool write command");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("pool read and write in the same cycle");

	a_result_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> !out_valid_q)
		else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/npt_ctrl.sv
// Controller of the address pool translator: sequences clearing, owner search, free scan and reply.
// Depends on npt_pkg; drives npt_dp through registered commands.
`default_nettype none

module npt_ctrl import npt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      take,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_OWNER,
		ST_FREE_PREP,
		ST_FREE,
		ST_INBOUND,
		ST_RESP
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	res_t   res_q;

	assign in_stall = (state_q != ST_IDLE);
	assign take     = (state_q == ST_IDLE) && in_valid;
	assign cmd      = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin : p_fsm
		cmd_t cmd_n;
		if (!arst_n) begin
			cmd_n     = '0;
			cmd_n.clr = 1'b1;
			state_q   <= ST_CLEAR;
			cmd_q     <= cmd_n;
			res_q     <= RES_FAIL;
		end else begin
			cmd_n = '0;
			case (state_q)
				ST_CLEAR: begin
					if (sts.cnt_last) begin
						state_q <= ST_IDLE;
					end else begin
						cmd_n.clr = 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					case (sts.op)
						OP_OUTBOUND: begin
							cmd_n.scan_owner = 1'b1;
							state_q          <= ST_OWNER;
						end
						OP_RELEASE: begin
							cmd_n.scan_owner = 1'b1;
							state_q          <= ST_OWNER;
						end
						OP_INBOUND: begin
							cmd_n.rd_in = 1'b1;
							state_q     <= ST_INBOUND;
						end
						default: begin
							res_q   <= RES_FAIL;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_OWNER: begin
					if (sts.found) begin
						if (sts.op == OP_RELEASE) begin
							cmd_n.wr_free = 1'b1;
							res_q         <= RES_RELEASED;
						end else begin
							res_q <= RES_PUBLIC;
						end
						state_q <= ST_RESP;
					end else if (sts.scan_over) begin
						if (sts.op == OP_RELEASE) begin
							res_q   <= RES_FAIL;
							state_q <= ST_RESP;
						end else begin
							cmd_n.restart = 1'b1;
							state_q       <= ST_FREE_PREP;
						end
					end else begin
						cmd_n.scan_owner = 1'b1;
					end
				end
				ST_FREE_PREP: begin
					cmd_n.scan_free = 1'b1;
					state_q         <= ST_FREE;
				end
				ST_FREE: begin
					if (sts.found) begin
						cmd_n.wr_bind = 1'b1;
						res_q         <= RES_PUBLIC;
						state_q       <= ST_RESP;
					end else if (sts.scan_over) begin
						res_q   <= RES_FAIL;
						state_q <= ST_RESP;
					end else begin
						cmd_n.scan_free = 1'b1;
					end
				end
				ST_INBOUND: begin
					res_q   <= RES_INBOUND;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (sts.out_free) begin
						cmd_n.result = 1'b1;
						cmd_n.res    = res_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			cmd_q <= cmd_n;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nat_pool_translator.sv
// Top level of the address pool translator: ties the controller to the datapath.
// Depends on npt_pkg, npt_ctrl and npt_dp.
//
// Address pool translator. The pool holds 2**POOL_BITS public addresses; slot i
// stands for pool_base with its low POOL_BITS bits replaced by i. Each request
// carries an operation and an address and yields exactly one result (ok plus
// translated). Outbound (0) returns the public address bound to the internal
// address, or binds the first free slot at or after the rotating scan pointer
// and moves the pointer past it; ok is 0 when the pool is full. Inbound (1)
// maps a public address back to its owner; ok is 0 when the slot is free or the
// prefix does not match. Release (2) frees the binding of an internal address.
// Code 3 answers ok=0. translated is 0 whenever ok is 0 and for every release.
// pool_base is to be written through cfg_we/cfg_wdata by the user only while
// no request is in flight; the block does not enforce it. Bindings survive a
// prefix change and show the new prefix from then on. The pool sits in a
// memory with one write port and one registered read port; owner search and
// free scan read one slot per clock and walk the slots one per cycle. An
// outbound request without a binding runs the owner search and then the free
// scan. After reset the block runs a clearing pass over every slot of the
// pool before it takes its first request; configuration writes are taken
// throughout. A finished result sits in an output register, so the next
// request can be accepted while the result still waits on out_stall.
`default_nettype none

module nat_pool_translator import npt_pkg::*; #(
	parameter int unsigned POOL_BITS = POOL_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: pool_base
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        operation,
	input  wire logic [ADDR_W-1:0] address,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   ok,
	output logic [ADDR_W-1:0]      translated
);

	logic take;
	cmd_t cmd;
	sts_t sts;

	// Sequence each request: dispatch, owner search, free scan, write back, reply.
	npt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.take     (take),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Hold the pool memory, the scan pointer, the prefix and the result register.
	npt_dp #(
		.POOL_BITS (POOL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.cmd        (cmd),
		.sts        (sts),
		.operation  (operation),
		.address    (address),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.ok         (ok),
		.translated (translated)
	);

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for nat_pool_translator: directed and random pool traffic, scored by a
// built-in model of the pool with random idling on both channels.
// Depends on npt_pkg and the nat_pool_translator RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npt_pkg::*;

	localparam int          POOL_SIZE   = 1 << POOL_BITS_DEF;
	localparam logic [31:0] HOST_MASK   = POOL_SIZE - 1;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	// Longest quiet stretch of a correct run is one allocation that walks both
	// scans plus the worst sender gap and receiver stall; take several times
	// that.
	localparam int          QUIET_LIMIT = 4000;
	localparam int          DRAIN_TAIL  = 600;

	typedef struct {
		bit          ok;
		logic [31:0] translated;
	} xlat_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [31:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        ok;
	logic [31:0] translated;

	// Pool model: which slots are bound, to whom, and where the next scan starts.
	bit          slot_bound [POOL_SIZE];
	logic [31:0] slot_owner_m [POOL_SIZE];
	int          scan_pos;
	logic [31:0] pool_base_m;

	xlat_result_t expected_xlat [$];
	xlat_result_t want;
	int           error_count = 0;
	int           out_hold = 0;
	int           quiet_cycles = 0;
	bit           back_to_back = 1'b0;

	nat_pool_translator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.translated (translated)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Pool model
	// ------------------------------------------------------------------

	function automatic logic [31:0] pool_prefix();
		return pool_base_m & ~HOST_MASK;
	endfunction

	// Return the bound slot owned by addr, or -1 when addr holds no binding.
	function automatic int owner_slot(input logic [31:0] addr);
		int hit;
		hit = -1;
		for (int i = POOL_SIZE - 1; i >= 0; i--)
			if (slot_bound[i] && slot_owner_m[i] == addr)
				hit = i;
		return hit;
	endfunction

	function automatic int busy_slots();
		int n;
		n = 0;
		for (int i = 0; i < POOL_SIZE; i++)
			n += slot_bound[i];
		return n;
	endfunction

	// Advance the pool model by one request and return the result it must produce.
	function automatic void apply_request(input logic [1:0] op, input logic [31:0] addr,
			output xlat_result_t res);
		int  slot;
		int  idx;
		bit  taken;
		res.ok = 1'b0;
		res.translated = '0;
		taken = 1'b0;
		case (op)
			OP_OUTBOUND: begin
				slot = owner_slot(addr);
				if (slot >= 0) begin
					res.ok = 1'b1;
					res.translated = pool_prefix() | slot;
				end else begin
					// Round-robin scan for the first free slot from the pointer.
					for (int i = 0; i < POOL_SIZE; i++) begin
						idx = (scan_pos + i) % POOL_SIZE;
						if (!taken && !slot_bound[idx]) begin
							taken = 1'b1;
							slot_bound[idx] = 1'b1;
							slot_owner_m[idx] = addr;
							scan_pos = (idx + 1) % POOL_SIZE;
							res.ok = 1'b1;
							res.translated = pool_prefix() | idx;
						end
					end
				end
			end
			OP_INBOUND: begin
				slot = addr & HOST_MASK;
				if (slot_bound[slot] && (addr & ~HOST_MASK) == pool_prefix()) begin
					res.ok = 1'b1;
					res.translated = slot_owner_m[slot];
				end
			end
			OP_RELEASE: begin
				slot = owner_slot(addr);
				if (slot >= 0) begin
					slot_bound[slot] = 1'b0;
					res.ok = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// Pick the owner of some bound slot; fall back to a fresh address on an empty pool.
	function automatic logic [31:0] pick_bound_owner();
		int start;
		int idx;
		logic [31:0] addr;
		start = $urandom_range(0, POOL_SIZE - 1);
		addr = $urandom;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			idx = (start + i) % POOL_SIZE;
			if (slot_bound[idx])
				addr = slot_owner_m[idx];
		end
		return addr;
	endfunction

	// Pick a public address: mostly a bound slot under the current prefix,
	// sometimes any slot, sometimes anything at all.
	function automatic logic [31:0] pick_public();
		int start;
		int idx;
		int slot;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return pool_prefix() | $urandom_range(0, POOL_SIZE - 1);
			default: begin
				start = $urandom_range(0, POOL_SIZE - 1);
				slot = start;
				for (int i = POOL_SIZE - 1; i >= 0; i--) begin
					idx = (start + i) % POOL_SIZE;
					if (slot_bound[idx])
						slot = idx;
				end
				return pool_prefix() | slot;
			end
		endcase
	endfunction

	function automatic int draw_wait();
		return back_to_back ? 0 : $urandom_range(0, 9);
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Present one request after a random gap, hold it until taken, then
	// record what the block must answer. Valid stays high on return so a
	// zero gap gives back-to-back requests.
	task automatic send_request(input logic [1:0] op, input logic [31:0] addr);
		int           gap;
		xlat_result_t res;
		gap = draw_wait();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		address   <= addr;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		apply_request(op, addr, res);
		expected_xlat.insert(expected_xlat.size(), res);
	endtask

	// Drop valid and wait until every outstanding result has come back. Each
	// request yields exactly one result, so an empty queue means the block is idle.
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_xlat.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_pool_base(input logic [31:0] value);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		pool_base_m = value;
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Hold stall for the drawn number of cycles in which a result is waiting.
	always @(negedge clk) begin
		out_stall <= (out_hold != 0);
		if (out_valid === 1'b1 && out_hold != 0)
			out_hold--;
	end

	// Score each result against the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_xlat.size() == 0) begin
				$error("unexpected result: ok=%0b translated=%h", ok, translated);
				error_count++;
			end else begin
				want = expected_xlat.pop_front();
				if (ok !== want.ok) begin
					$error("ok mismatch: expected %0b, got %0b", want.ok, ok);
					error_count++;
				end
				if (translated !== want.translated) begin
					$error("translated mismatch: expected %h, got %h",
						want.translated, translated);
					error_count++;
				end
			end
			out_hold = draw_wait();
		end
	end

	// Abort when nothing moves on any port for too long.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("nat_pool_translator test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Basic operations on the cleared pool with the reset prefix of zero:
	// misses on an empty pool, new and existing bindings, release and
	// double release, the unused code, and round-robin moving past a freed slot.
	task automatic test_basic_ops();
		send_request(OP_INBOUND,  32'h0000_0000);  // slot free
		send_request(OP_RELEASE,  32'h0000_0000);  // no binding
		send_request(OP_UNUSED,   32'hFFFF_FFFF);
		send_request(OP_OUTBOUND, 32'h0000_0000);  // binds slot 0
		send_request(OP_OUTBOUND, 32'hFFFF_FFFF);  // binds slot 1
		send_request(OP_OUTBOUND, 32'h0000_0000);  // existing binding
		send_request(OP_INBOUND,  32'h0000_0001);
		send_request(OP_INBOUND,  32'h8000_0001);  // prefix mismatch
		send_request(OP_RELEASE,  32'h0000_0000);
		send_request(OP_RELEASE,  32'h0000_0000);  // already released
		send_request(OP_INBOUND,  32'h0000_0000);  // freed slot
		send_request(OP_OUTBOUND, 32'h1234_5678);  // skips freed slot 0
	endtask

	// Prefix changes keep bindings and re-label them; low host bits of the
	// register are ignored.
	task automatic test_prefix_change();
		write_pool_base(32'hFFFF_FFFF);
		send_request(OP_INBOUND,  32'hFFFF_FF01);
		send_request(OP_OUTBOUND, 32'h1234_5678);
		send_request(OP_INBOUND,  32'h0000_0001);  // old prefix
		send_request(OP_INBOUND,  32'hFFFF_FFFF);  // top slot free
		write_pool_base(32'hC0A8_0A37);
		send_request(OP_OUTBOUND, 32'hFFFF_FFFF);
		send_request(OP_INBOUND,  32'hC0A8_0A02);
		send_request(OP_RELEASE,  32'hFFFF_FFFF);
		send_request(OP_UNUSED,   32'hC0A8_0A02);
		send_request(OP_RELEASE,  32'h1234_5678);
	endtask

	// Fill the pool with fresh owners plus some noise, hit the full pool,
	// then free a handful and refill so the scan wraps onto scattered holes.
	task automatic test_pool_exhaust();
		int n;
		write_pool_base($urandom);
		n = 0;
		while (busy_slots() < POOL_SIZE) begin
			back_to_back = (n >= 40 && n < 80);
			case ($urandom_range(0, 19))
				0:       send_request(OP_OUTBOUND, pick_bound_owner());
				1:       send_request(OP_INBOUND, pick_public());
				2:       send_request(OP_RELEASE, $urandom);
				3:       send_request(OP_UNUSED, $urandom);
				default: send_request(OP_OUTBOUND, $urandom);
			endcase
			n++;
		end
		back_to_back = 1'b0;
		repeat (4) send_request(OP_OUTBOUND, $urandom);
		repeat (3) send_request(OP_OUTBOUND, pick_bound_owner());
		repeat (3) send_request(OP_INBOUND, pick_public());
		repeat (12) send_request(OP_RELEASE, pick_bound_owner());
		repeat (16) send_request(OP_OUTBOUND, $urandom);
	endtask

	// Mixed churn under several prefixes, zero among them.
	task automatic test_random_mix();
		for (int phase = 0; phase < 3; phase++) begin
			write_pool_base(phase == 1 ? 32'h0000_0000 : $urandom);
			for (int n = 0; n < 40; n++) begin
				back_to_back = (n >= 10 && n < 25);
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4:          send_request(OP_OUTBOUND, $urandom);
					5, 6, 7:                send_request(OP_OUTBOUND, pick_bound_owner());
					8, 9, 10, 11:           send_request(OP_INBOUND, pick_public());
					12, 13, 14, 15, 16, 17: send_request(OP_RELEASE, pick_bound_owner());
					18:                     send_request(OP_RELEASE, $urandom);
					default:                send_request(OP_UNUSED, $urandom);
				endcase
			end
			back_to_back = 1'b0;
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		operation = OP_OUTBOUND;
		address   = '0;
		out_stall = 1'b0;
		pool_base_m = '0;
		scan_pos    = 0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			slot_bound[i]   = 1'b0;
			slot_owner_m[i] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_prefix_change();
		test_pool_exhaust();
		test_random_mix();

		// Drain, then give a stray extra result time to show up.
		settle_idle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (error_count == 0)
			$display("nat_pool_translator test passed");
		else
			$display("nat_pool_translator test failed");
		$finish;
	end

endmodule

FILE: nat_pool_translator.f
hw/rtl/npt_pkg.sv
hw/rtl/npt_dp.sv
hw/rtl/npt_ctrl.sv
hw/rtl/nat_pool_translator.sv
dv/tb.sv
